// ===== rtl/sjt_pkg.sv =====
// Shared types, constants and helpers of the sinusoidal joint trajectory block.
// No dependencies.
package sjt_pkg;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam logic [30:0] PI_Q29 = 31'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_t;

  // Per-request data riding along the rotation cells.
  typedef struct packed {
    logic [3:0]         joint;
    logic [1:0]         quad;
    logic signed [15:0] off;
    logic [14:0]        amp;
    logic [41:0]        aw32;
    logic [56:0]        p;
  } side_t;

  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] a;
    unique case (i)
      0:  a = 30'd843314857;
      1:  a = 30'd497837829;
      2:  a = 30'd263043837;
      3:  a = 30'd133525159;
      4:  a = 30'd67021687;
      5:  a = 30'd33543516;
      6:  a = 30'd16775851;
      7:  a = 30'd8388437;
      8:  a = 30'd4194283;
      9:  a = 30'd2097149;
      10: a = 30'd1048576;
      11: a = 30'd524288;
      12: a = 30'd262144;
      13: a = 30'd131072;
      14: a = 30'd65536;
      15: a = 30'd32768;
      16: a = 30'd16384;
      17: a = 30'd8192;
      18: a = 30'd4096;
      19: a = 30'd2048;
      20: a = 30'd1024;
      21: a = 30'd512;
      22: a = 30'd256;
      default: a = 30'd128;
    endcase
    return a;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7FFF;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/sjt_prep.sv =====
// Front end: phase accumulation, angle scaling and amplitude/frequency products.
// Three register stages. Depends on sjt_pkg.
module sjt_prep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vin,
  input  logic [3:0]            joint,
  input  logic [31:0]           time_s,
  input  logic [15:0]           offset,
  input  logic [14:0]           amplitude,
  input  logic [19:0]           frequency,
  input  logic [15:0]           phase,
  output logic                  vout,
  output sjt_pkg::cordic_t      c_o,
  output sjt_pkg::side_t        s_o
);

  logic [2:0] v_r;

  // stage 1
  logic [31:0] turn_r;
  logic [38:0] w32_r;
  logic [3:0]  j1_r;
  logic [15:0] off1_r;
  logic [14:0] amp1_r;
  logic [51:0] ft;
  logic [50:0] fw;
  logic [31:0] turn_nxt;
  logic [38:0] w32_nxt;

  // stage 2
  logic [30:0] z_r;
  logic [41:0] aw32_r;
  logic [22:0] w16_r;
  logic [1:0]  quad_r;
  logic [3:0]  j2_r;
  logic [15:0] off2_r;
  logic [14:0] amp2_r;
  logic [60:0] fz;
  logic [53:0] aw;
  logic [38:0] w16s;

  // stage 3
  logic [41:0] aw8s;
  logic [56:0] p_nxt;
  sjt_pkg::side_t s_r;
  logic [30:0]    z3_r;

  always_comb begin
    ft       = 52'(frequency) * 52'(time_s);
    turn_nxt = ft[31:0] + {phase, 16'h0000};
    fw       = 51'(frequency) * 51'(sjt_pkg::PI_Q29) + 51'd2048;
    w32_nxt  = fw[50:12];
    fz       = 61'(turn_r[29:0]) * 61'(sjt_pkg::PI_Q29) + 61'd536870912;
    aw       = 54'(amp1_r) * 54'(w32_r) + 54'd2048;
    w16s     = w32_r + 39'd32768;
    aw8s     = aw32_r + 42'd128;
    p_nxt    = 57'(aw8s[41:8]) * 57'(w16_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      turn_r  <= turn_nxt;
      w32_r   <= w32_nxt;
      j1_r    <= joint;
      off1_r  <= offset;
      amp1_r  <= amplitude;

      z_r     <= fz[60:30];
      aw32_r  <= aw[53:12];
      w16_r   <= w16s[38:16];
      quad_r  <= turn_r[31:30];
      j2_r    <= j1_r;
      off2_r  <= off1_r;
      amp2_r  <= amp1_r;

      z3_r       <= z_r;
      s_r.joint  <= j2_r;
      s_r.quad   <= quad_r;
      s_r.off    <= off2_r;
      s_r.amp    <= amp2_r;
      s_r.aw32   <= aw32_r;
      s_r.p      <= p_nxt;
    end
  end

  assign vout  = v_r[2];
  assign c_o.x = sjt_pkg::CORDIC_GAIN_Q30;
  assign c_o.y = '0;
  assign c_o.z = {3'b000, z3_r};
  assign s_o   = s_r;

endmodule

// ===== rtl/sjt_cell.sv =====
// One CORDIC rotation step with its pipeline register.
// Depends on sjt_pkg.
module sjt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vin,
  input  sjt_pkg::cordic_t c_i,
  input  sjt_pkg::side_t   s_i,
  output logic             vout,
  output sjt_pkg::cordic_t c_o,
  output sjt_pkg::side_t   s_o
);

  logic             v_r;
  sjt_pkg::cordic_t c_r, c_nxt;
  sjt_pkg::side_t   s_r;
  logic signed [33:0] dx, dy, at;

  always_comb begin
    dx = $signed(c_i.y) >>> STEP;
    dy = $signed(c_i.x) >>> STEP;
    at = $signed({4'b0000, sjt_pkg::atan_q30(STEP)});
    if (!c_i.z[33]) begin
      c_nxt.x = c_i.x - dx;
      c_nxt.y = c_i.y + dy;
      c_nxt.z = c_i.z - at;
    end else begin
      c_nxt.x = c_i.x + dx;
      c_nxt.y = c_i.y - dy;
      c_nxt.z = c_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
      s_r <= s_i;
    end
  end

  assign vout = v_r;
  assign c_o  = c_r;
  assign s_o  = s_r;

endmodule

// ===== rtl/sjt_post.sv =====
// Back end: quadrant fold, split products, rounding and saturation.
// Two register stages, the second is the result register. Depends on sjt_pkg.
module sjt_post (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vin,
  input  sjt_pkg::cordic_t   c_i,
  input  sjt_pkg::side_t     s_i,
  output logic               vout,
  output logic [3:0]         joint_o,
  output logic signed [15:0] pos_o,
  output logic signed [31:0] vel_o,
  output logic signed [31:0] acc_o
);

  localparam logic signed [63:0] R16 = 64'sd32768;
  localparam logic signed [63:0] R24 = 64'sd8388608;
  localparam logic signed [64:0] R30W = 65'sd536870912;
  localparam logic signed [63:0] R30 = 64'sd536870912;

  logic [1:0] v_r;

  logic signed [33:0] sn, cs;
  logic signed [49:0] pa_r, pa_nxt;
  logic signed [46:0] vhi_r, vhi_nxt;
  logic signed [64:0] vlo_r, vlo_nxt, alo_r, alo_nxt;
  logic signed [61:0] ahi_r, ahi_nxt;
  logic [3:0]         j_r, jo_r;
  logic signed [15:0] off_r;

  logic signed [63:0] pr, vr, ar, v30, a30;
  logic signed [15:0] pos_r;
  logic signed [31:0] vel_r, acc_r;

  always_comb begin
    unique case (s_i.quad)
      2'd0: begin sn = c_i.y;  cs = c_i.x;  end
      2'd1: begin sn = c_i.x;  cs = -c_i.y; end
      2'd2: begin sn = -c_i.y; cs = -c_i.x; end
      default: begin sn = -c_i.x; cs = c_i.y; end
    endcase
    pa_nxt  = 50'($signed({1'b0, s_i.amp})) * 50'(sn);
    vhi_nxt = 47'($signed({1'b0, s_i.aw32[41:30]})) * 47'(cs);
    vlo_nxt = 65'($signed({1'b0, s_i.aw32[29:0]})) * 65'(cs);
    ahi_nxt = 62'($signed({1'b0, s_i.p[56:30]})) * 62'(sn);
    alo_nxt = 65'($signed({1'b0, s_i.p[29:0]})) * 65'(sn);
  end

  always_comb begin
    pr  = (64'(pa_r) + R30) >>> 30;
    vr  = 64'((vlo_r + R30W) >>> 30);
    ar  = 64'((alo_r + R30W) >>> 30);
    v30 = 64'(vhi_r) + vr;
    a30 = 64'(ahi_r) + ar;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= pa_nxt;
      vhi_r <= vhi_nxt;
      vlo_r <= vlo_nxt;
      ahi_r <= ahi_nxt;
      alo_r <= alo_nxt;
      j_r   <= s_i.joint;
      off_r <= s_i.off;

      jo_r  <= j_r;
      pos_r <= sjt_pkg::sat16(64'(off_r) + pr);
      vel_r <= sjt_pkg::sat32((v30 + R16) >>> 16);
      acc_r <= sjt_pkg::sat32(-((a30 + R24) >>> 24));
    end
  end

  assign vout    = v_r[1];
  assign joint_o = jo_r;
  assign pos_o   = pos_r;
  assign vel_o   = vel_r;
  assign acc_o   = acc_r;

endmodule

// ===== rtl/sinusoid_joint_trajectory_top.sv =====
// Sinusoidal joint trajectory generator: top level, pipeline stall control.
// Depends on sjt_pkg, sjt_prep, sjt_cell, sjt_post.
//
// Each request carries one joint's time and sine parameters and yields one
// result: position = offset + A*sin(theta), velocity = A*w*cos(theta) and
// acceleration = -A*w^2*sin(theta), with w = 2*pi*f and theta taken in turns
// from f*t + phase (wrapping). Sine and cosine come from a chain of 24 CORDIC
// rotation cells, one step per cell. The block is a 29-stage pipeline: three
// front stages, 24 cells, two back stages ending in the result register.
// It takes one request per cycle while not stalled. The whole pipeline
// holds only while the result register is full and out_ready is low.
// Results come back in request order; joint numbers pass through unchecked.
module sinusoid_joint_trajectory_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_joint,
  input  logic [31:0]        in_time_s,
  input  logic signed [15:0] in_offset,
  input  logic [14:0]        in_amplitude,
  input  logic [19:0]        in_frequency,
  input  logic [15:0]        in_phase,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_joint_out,
  output logic signed [15:0] out_position,
  output logic signed [31:0] out_velocity,
  output logic signed [31:0] out_acceleration
);

  localparam int unsigned N = sjt_pkg::CORDIC_STEPS;

  // global advance: every stage moves when the result register can take data
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic             v_chain [N+1];
  sjt_pkg::cordic_t c_chain [N+1];
  sjt_pkg::side_t   s_chain [N+1];

  sjt_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vin       (in_valid),
    .joint     (in_joint),
    .time_s    (in_time_s),
    .offset    (in_offset),
    .amplitude (in_amplitude),
    .frequency (in_frequency),
    .phase     (in_phase),
    .vout      (v_chain[0]),
    .c_o       (c_chain[0]),
    .s_o       (s_chain[0])
  );

  // rotation cells, step k shifts by k
  for (genvar k = 0; k < N; k++) begin : g_cell
    sjt_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vin   (v_chain[k]),
      .c_i   (c_chain[k]),
      .s_i   (s_chain[k]),
      .vout  (v_chain[k+1]),
      .c_o   (c_chain[k+1]),
      .s_o   (s_chain[k+1])
    );
  end

  sjt_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vin     (v_chain[N]),
    .c_i     (c_chain[N]),
    .s_i     (s_chain[N]),
    .vout    (out_valid),
    .joint_o (out_joint_out),
    .pos_o   (out_position),
    .vel_o   (out_velocity),
    .acc_o   (out_acceleration)
  );

`ifndef SYNTHESIS
  a_stall_only_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("pipeline stalled without a blocked result");

  a_drop_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result withdrawn before it was taken");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
